// ===== hw/rtl/gaussian_covariance_from_quat_scale_macros.svh =====
// ---------------------------------------------------------------------------
// gaussian covariance assertion macros
// shared property shorthands, clocked on clk and disabled in rst
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_COVARIANCE_FROM_QUAT_SCALE_MACROS_SVH
`define GAUSSIAN_COVARIANCE_FROM_QUAT_SCALE_MACROS_SVH

// same-cycle implication
`define GCQ_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("gcq implication check failed");

// fixed-delay implication
`define GCQ_ASSERT_DLY(lbl, a, n, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> ## n (b)) \
    else $error("gcq latency check failed");

`endif

// ===== hw/rtl/gcq_pkg.sv =====
// ---------------------------------------------------------------------------
// gcq_pkg
// widths, fixed-point constants and entry pair tables for the covariance block
// ---------------------------------------------------------------------------
package gcq_pkg;

  localparam int unsigned IN_W      = 16;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned FRAC_R    = 30;
  localparam int unsigned DIV_STEPS = FRAC_R + 1;
  localparam int unsigned N2_W      = 33;
  // edges from input accept to result accept
  localparam int unsigned LATENCY   = DIV_STEPS + 9;

  typedef logic signed [IN_W-1:0]  in_t;
  typedef logic signed [OUT_W-1:0] out_t;

  // row and column of the six unique covariance entries
  localparam int unsigned PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned PAIR_J [6] = '{0, 1, 2, 1, 2, 2};

endpackage

// ===== hw/rtl/gaussian_covariance_from_quat_scale.sv =====
// A result passes the input, products, numerator, divider, covariance and output registers in turn.
// Throughput: one gaussian per cycle; busy stays low, nothing ever stalls.
// Depth is set by the 31-stage restoring divider that forms R = M / |q|^2.
// Reset: rst (synchronous) clears all stage valid bits; in-flight items are dropped.
// The receiver cannot stall; done marks each result for one cycle.
// ---------------------------------------------------------------------------
// gaussian_covariance_from_quat_scale
// 3d gaussian covariance R*S^2*R^T from scale and unnormalized quaternion
// ---------------------------------------------------------------------------
`include "gaussian_covariance_from_quat_scale_macros.svh"

module gaussian_covariance_from_quat_scale (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  gcq_pkg::in_t   scale_x,
  input  gcq_pkg::in_t   scale_y,
  input  gcq_pkg::in_t   scale_z,
  input  gcq_pkg::in_t   quat_w,
  input  gcq_pkg::in_t   quat_x,
  input  gcq_pkg::in_t   quat_y,
  input  gcq_pkg::in_t   quat_z,
  output logic           done,
  output gcq_pkg::out_t  cov_xx,
  output gcq_pkg::out_t  cov_xy,
  output gcq_pkg::out_t  cov_xz,
  output gcq_pkg::out_t  cov_yy,
  output gcq_pkg::out_t  cov_yz,
  output gcq_pkg::out_t  cov_zz,
  output logic           degenerate_quat
);
  import gcq_pkg::*;

  localparam int unsigned NS = DIV_STEPS;

  // input stage
  logic  iv;
  in_t   i_sc [3];
  in_t   i_w, i_x, i_y, i_z;

  // products stage
  logic               av;
  logic signed [31:0] a_s2 [3];
  logic signed [31:0] a_ww, a_xx, a_yy, a_zz;
  logic signed [31:0] a_xy, a_zw, a_xz, a_yw, a_yz, a_xw;

  // rotation numerator stage
  logic               bv;
  logic signed [31:0] b_s2 [3];
  logic [N2_W-1:0]    b_n2;
  logic [N2_W-1:0]    b_mag [9];
  logic               b_neg [9];
  logic               b_deg;
  logic signed [33:0] m_raw [9];
  logic signed [33:0] n2_sum;

  // divider pipeline, index 0 is the load stage
  logic               dv_vld [NS+1];
  logic [N2_W-1:0]    dv_rem [NS+1][9];
  logic [NS-1:0]      dv_lo  [NS+1][9];
  logic [NS-1:0]      dv_q   [NS+1][9];
  logic               dv_neg [NS+1][9];
  logic [N2_W-1:0]    dv_d   [NS+1];
  logic signed [31:0] dv_s2  [NS+1][3];
  logic               dv_deg [NS+1];
  logic [62:0]        num    [9];

  // covariance stages
  logic               ev, fv, gv, hv;
  logic signed [31:0] r_fin [3][3];
  logic signed [63:0] e_p [6][3];
  logic signed [31:0] e_s2 [3];
  logic               e_deg;
  logic signed [31:0] f_rr [6][3];
  logic signed [31:0] f_s2 [3];
  logic               f_deg;
  logic signed [63:0] g_t [6][3];
  logic               g_deg;
  logic signed [35:0] h_sum [6];
  logic               h_deg;
  out_t               sat [6];
  logic               cov_nz;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
      av <= 1'b0;
      bv <= 1'b0;
      ev <= 1'b0;
      fv <= 1'b0;
      gv <= 1'b0;
      hv <= 1'b0;
      done <= 1'b0;
      for (int s = 0; s <= NS; s++) dv_vld[s] <= 1'b0;
    end else begin
      iv <= start;
      av <= iv;
      bv <= av;
      dv_vld[0] <= bv;
      for (int s = 0; s < NS; s++) dv_vld[s+1] <= dv_vld[s];
      ev <= dv_vld[NS];
      fv <= ev;
      gv <= fv;
      hv <= gv;
      done <= hv;
    end
  end

  // numerator entries of the rotation matrix and their magnitudes
  always_comb begin
    n2_sum = 34'(a_ww) + 34'(a_xx) + 34'(a_yy) + 34'(a_zz);
    m_raw[0] = 34'(a_ww) + 34'(a_xx) - 34'(a_yy) - 34'(a_zz);
    m_raw[1] = (34'(a_xy) - 34'(a_zw)) <<< 1;
    m_raw[2] = (34'(a_xz) + 34'(a_yw)) <<< 1;
    m_raw[3] = (34'(a_xy) + 34'(a_zw)) <<< 1;
    m_raw[4] = 34'(a_ww) - 34'(a_xx) + 34'(a_yy) - 34'(a_zz);
    m_raw[5] = (34'(a_yz) - 34'(a_xw)) <<< 1;
    m_raw[6] = (34'(a_xz) - 34'(a_yw)) <<< 1;
    m_raw[7] = (34'(a_yz) + 34'(a_xw)) <<< 1;
    m_raw[8] = 34'(a_ww) - 34'(a_xx) - 34'(a_yy) + 34'(a_zz);
  end

  // dividend = |m| * 2^30 + n2 / 2, quotient bits above bit 30 are zero
  always_comb begin
    for (int l = 0; l < 9; l++) begin
      num[l] = {b_mag[l], {FRAC_R{1'b0}}} + 63'(b_n2 >> 1);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        r_fin[i][k] = dv_neg[NS][i*3+k] ? -32'(dv_q[NS][i*3+k])
                                          : 32'(dv_q[NS][i*3+k]);
      end
    end
  end

  always_comb begin
    for (int e = 0; e < 6; e++) begin
      if (h_sum[e] > 36'sd2147483647) begin
        sat[e] = 32'sh7fffffff;
      end else if (h_sum[e] < -36'sd2147483648) begin
        sat[e] = 32'sh80000000;
      end else begin
        sat[e] = h_sum[e][31:0];
      end
    end
  end

  assign cov_nz = |{cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz};

  always_ff @(posedge clk) begin
    i_sc[0] <= scale_x;
    i_sc[1] <= scale_y;
    i_sc[2] <= scale_z;
    i_w <= quat_w;
    i_x <= quat_x;
    i_y <= quat_y;
    i_z <= quat_z;

    for (int k = 0; k < 3; k++) a_s2[k] <= i_sc[k] * i_sc[k];
    a_ww <= i_w * i_w;
    a_xx <= i_x * i_x;
    a_yy <= i_y * i_y;
    a_zz <= i_z * i_z;
    a_xy <= i_x * i_y;
    a_zw <= i_z * i_w;
    a_xz <= i_x * i_z;
    a_yw <= i_y * i_w;
    a_yz <= i_y * i_z;
    a_xw <= i_x * i_w;

    b_s2 <= a_s2;
    b_n2 <= n2_sum[N2_W-1:0];
    b_deg <= (n2_sum == '0);
    for (int l = 0; l < 9; l++) begin
      b_neg[l] <= m_raw[l][33];
      b_mag[l] <= m_raw[l][33] ? 33'(-m_raw[l]) : m_raw[l][N2_W-1:0];
    end

    // load stage
    dv_d[0] <= b_n2;
    dv_s2[0] <= b_s2;
    dv_deg[0] <= b_deg;
    for (int l = 0; l < 9; l++) begin
      dv_rem[0][l] <= {1'b0, num[l][62:FRAC_R+1]};
      dv_lo[0][l] <= num[l][FRAC_R:0];
      dv_q[0][l] <= '0;
      dv_neg[0][l] <= b_neg[l];
    end

    // one quotient bit per stage
    for (int s = 0; s < NS; s++) begin
      dv_d[s+1] <= dv_d[s];
      dv_s2[s+1] <= dv_s2[s];
      dv_deg[s+1] <= dv_deg[s];
      for (int l = 0; l < 9; l++) begin
        dv_neg[s+1][l] <= dv_neg[s][l];
        dv_lo[s+1][l] <= dv_lo[s][l] << 1;
        if ({dv_rem[s][l], dv_lo[s][l][NS-1]} >= {1'b0, dv_d[s]}) begin
          dv_rem[s+1][l] <= 33'({dv_rem[s][l], dv_lo[s][l][NS-1]} - {1'b0, dv_d[s]});
          dv_q[s+1][l] <= {dv_q[s][l][NS-2:0], 1'b1};
        end else begin
          dv_rem[s+1][l] <= {dv_rem[s][l][N2_W-2:0], dv_lo[s][l][NS-1]};
          dv_q[s+1][l] <= {dv_q[s][l][NS-2:0], 1'b0};
        end
      end
    end

    // R_ik * R_jk in q.60
    e_s2 <= dv_s2[NS];
    e_deg <= dv_deg[NS];
    for (int e = 0; e < 6; e++) begin
      for (int k = 0; k < 3; k++) begin
        e_p[e][k] <= r_fin[PAIR_I[e]][k] * r_fin[PAIR_J[e]][k];
      end
    end

    // round to q.30, half up
    f_s2 <= e_s2;
    f_deg <= e_deg;
    for (int e = 0; e < 6; e++) begin
      for (int k = 0; k < 3; k++) begin
        f_rr[e][k] <= 32'((e_p[e][k] + 64'sd536870912) >>> FRAC_R);
      end
    end

    g_deg <= f_deg;
    for (int e = 0; e < 6; e++) begin
      for (int k = 0; k < 3; k++) begin
        g_t[e][k] <= f_rr[e][k] * f_s2[k];
      end
    end

    // exact sum, then round q.46 to q16.16 half up
    h_deg <= g_deg;
    for (int e = 0; e < 6; e++) begin
      h_sum[e] <= 36'((g_t[e][0] + g_t[e][1] + g_t[e][2] + 64'sd536870912) >>> FRAC_R);
    end

    degenerate_quat <= h_deg;
    cov_xx <= h_deg ? '0 : sat[0];
    cov_xy <= h_deg ? '0 : sat[1];
    cov_xz <= h_deg ? '0 : sat[2];
    cov_yy <= h_deg ? '0 : sat[3];
    cov_yz <= h_deg ? '0 : sat[4];
    cov_zz <= h_deg ? '0 : sat[5];
  end

  `GCQ_ASSERT_DLY(a_latency, start && !busy, 40, done)
  `GCQ_ASSERT_IMP(a_deg_zero, done && degenerate_quat, !cov_nz)
  `GCQ_ASSERT_IMP(a_diag_pos, done && !degenerate_quat, !cov_xx[31] && !cov_yy[31] && !cov_zz[31])

endmodule
